[rtl/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
package spq_pkg;

   // Number of job slots in the cell chain
   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int PRIO_W   = 32;
   localparam int OCC_W    = 5;
   localparam int STAT_W   = 2;

   // Request kinds
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   // Result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Contents of one slot as handed between neighbor cells
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] data;
      logic signed [PRIO_W-1:0] prio;
   } slot_type;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert_en;
      logic remove_en;
   } cell_ctrl_type;

endpackage

[rtl/spq_cell.sv]
// One slot of the sorted chain: compares, holds, or shifts toward a neighbor.
module spq_cell
   import spq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cell_ctrl_type            ctrl,
   input  logic                     is_head,     // ties go in front of this slot
   input  logic                     earlier,     // new job lands in an earlier slot
   input  logic signed [DATA_W-1:0] new_data,
   input  logic signed [PRIO_W-1:0] new_prio,
   input  slot_type                 prev_slot,   // neighbor toward the head
   input  slot_type                 next_slot,   // neighbor toward the tail
   output slot_type                 slot,
   output logic                     take         // new job belongs here or earlier
);

   slot_type slot_ff;
   slot_type slot_in;

   // Placement test: head takes ties, later slots keep arrival order
   always_comb begin
      if (!slot_ff.valid) begin
         take = 1'b1;
      end else if (is_head) begin
         take = (new_prio <= slot_ff.prio);
      end else begin
         take = (new_prio < slot_ff.prio);
      end
   end

   // Next slot contents
   always_comb begin
      slot_in = slot_ff;
      if (ctrl.insert_en) begin
         if (earlier) begin
            slot_in = prev_slot;
         end else if (take) begin
            slot_in.valid = 1'b1;
            slot_in.data  = new_data;
            slot_in.prio  = new_prio;
         end
      end else if (ctrl.remove_en) begin
         slot_in = next_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.data <= slot_in.data;
      slot_ff.prio <= slot_in.prio;
   end

   assign slot = slot_ff;

endmodule

[rtl/sorted_priority_queue_core.sv]
// A result is registered at the clock edge that transfers its request.
// Throughput: one request per cycle unless results back up; the whole cell chain inserts or pops at once.
// A request is taken while the result register is empty or being drained.
// Reset (synchronous) clears all slot valid bits, the job count and the result
// valid bit; slot payloads and result payloads need no clearing.
module sorted_priority_queue_core
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // job_data [31:0], job_priority [63:32]
   input  logic [0:0]  req_tuser,   // opcode [0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // out_data [31:0], out_priority [63:32],
                                    // occupancy [68:64], zero [71:69]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   localparam int CNT_ONE = 1;

   slot_type                 slots [CAPACITY];
   logic     [CAPACITY-1:0]  takes;
   cell_ctrl_type            ctrl;
   op_type                   req_op;
   logic signed [DATA_W-1:0] req_data;
   logic signed [PRIO_W-1:0] req_prio;
   logic                     accept;
   logic                     full;
   logic                     empty;

   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   status_type               rsp_status_ff;
   status_type               rsp_status_in;
   logic signed [DATA_W-1:0] rsp_data_ff;
   logic signed [DATA_W-1:0] rsp_data_in;
   logic signed [PRIO_W-1:0] rsp_prio_ff;
   logic signed [PRIO_W-1:0] rsp_prio_in;
   logic [OCC_W-1:0]         rsp_occ_ff;
   logic [OCC_W-1:0]         rsp_occ_in;

   // Request unpacking and handshake
   assign req_op     = op_type'(req_tuser[0]);
   assign req_data   = req_tdata[DATA_W-1:0];
   assign req_prio   = req_tdata[DATA_W+PRIO_W-1:DATA_W];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign full  = slots[CAPACITY-1].valid;
   assign empty = !slots[0].valid;

   assign ctrl.insert_en = accept && (req_op == OP_INSERT) && !full;
   assign ctrl.remove_en = accept && (req_op == OP_REMOVE) && !empty;

   // Cell chain; slot 0 is the head
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      slot_type prev_s;
      slot_type next_s;
      logic     before_s;

      if (i == 0) begin : g_head
         assign prev_s   = '0;
         assign before_s = 1'b0;
      end else if (i == 1) begin : g_second
         assign prev_s   = slots[i-1];
         assign before_s = takes[0];
      end else begin : g_body
         // takes[1..] are monotone in a sorted chain, so one neighbor suffices
         assign prev_s   = slots[i-1];
         assign before_s = takes[0] || takes[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_s = '0;
      end else begin : g_mid
         assign next_s = slots[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .is_head   (i == 0),
         .earlier   (before_s),
         .new_data  (req_data),
         .new_prio  (req_prio),
         .prev_slot (prev_s),
         .next_slot (next_s),
         .slot      (slots[i]),
         .take      (takes[i])
      );
   end

   // Job count and result formation
   always_comb begin
      count_in = count_ff;
      if (ctrl.insert_en) begin
         count_in = count_ff + CNT_W'(CNT_ONE);
      end else if (ctrl.remove_en) begin
         count_in = count_ff - CNT_W'(CNT_ONE);
      end

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_DONE;
         rsp_data_in   = '0;
         rsp_prio_in   = '0;
         rsp_occ_in    = OCC_W'(count_in);
         case (req_op)
            OP_INSERT: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end
            end
            OP_REMOVE: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_data_in = slots[0].data;
                  rsp_prio_in = slots[0].prio;
               end
            end
            default: begin
               rsp_status_in = ST_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // Result packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_occ_ff, rsp_prio_ff, rsp_data_ff};

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the sorted priority queue core.
module testbench
   import spq_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_JOBS = 2000;
   localparam int CALM_TAIL   = 150;
   localparam int DRAIN_WAIT  = 8;

   typedef struct {
      op_type                   op;
      logic signed [DATA_W-1:0] data;
      logic signed [PRIO_W-1:0] prio;
   } job_request_type;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] data;
      logic signed [PRIO_W-1:0] prio;
      logic [OCC_W-1:0]         occupancy;
   } job_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;  // job_data [31:0], job_priority [63:32]
   logic [0:0]  req_tuser  = '0;  // opcode [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // out_data [31:0], out_priority [63:32], occupancy [68:64]
   logic [1:0]  rsp_tuser;        // status [1:0]

   job_request_type pending_jobs[$];
   job_result_type  expected_results[$];
   job_request_type driven_job;
   int              send_gap    = 0;
   int              stall_left  = 0;
   int              fail_count  = 0;
   int              cycle_count = 0;
   logic            calm_tail   = 1'b0;

   // Shadow copy of the sorted queue, slot 0 is the head
   logic signed [DATA_W-1:0] shadow_data [CAPACITY];
   logic signed [PRIO_W-1:0] shadow_prio [CAPACITY];
   int                       shadow_count = 0;

   sorted_priority_queue_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one request to the shadow queue and return the result it should give
   function automatic job_result_type apply_request(job_request_type r);
      job_result_type res;
      int             pos;
      int             i;
      res.status = ST_DONE;
      res.data   = '0;
      res.prio   = '0;
      if (r.op == OP_INSERT) begin
         if (shadow_count >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            // ties with the head go in front, ties elsewhere go behind
            pos = 0;
            if (shadow_count != 0 && r.prio > shadow_prio[0]) begin
               pos = 1;
               while (pos < shadow_count && shadow_prio[pos] <= r.prio)
                  pos++;
            end
            for (i = shadow_count; i > pos; i--) begin
               shadow_data[i] = shadow_data[i-1];
               shadow_prio[i] = shadow_prio[i-1];
            end
            shadow_data[pos] = r.data;
            shadow_prio[pos] = r.prio;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.data = shadow_data[0];
            res.prio = shadow_prio[0];
            for (i = 1; i < shadow_count; i++) begin
               shadow_data[i-1] = shadow_data[i];
               shadow_prio[i-1] = shadow_prio[i];
            end
            shadow_count--;
         end
      end
      res.occupancy = OCC_W'(shadow_count);
      return res;
   endfunction

   task automatic add_job(op_type op, logic [31:0] d, logic [31:0] p);
      job_request_type r;
      r.op   = op;
      r.data = d;
      r.prio = p;
      pending_jobs.push_back(r);
   endtask

   // Half the time narrow priorities to force ties, sometimes full range or near the extremes
   function automatic logic [31:0] pick_prio();
      logic [31:0] p;
      case ($urandom_range(0, 7))
         4, 5:    p = $urandom;
         6:       p = 32'h8000_0000 + $urandom_range(0, 2);
         7:       p = 32'h7fff_ffff - $urandom_range(0, 2);
         default: p = int'($urandom_range(0, 12)) - 6;
      endcase
      return p;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Request driver: holds each transfer until taken, random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         calm_tail <= (pending_jobs.size() < CALM_TAIL);
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_request(driven_job));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_jobs.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(1, 19) - 1;
               req_tvalid <= 1'b0;
            end else begin
               driven_job = pending_jobs.pop_front();
               req_tdata  <= {driven_job.prio, driven_job.data};
               req_tuser  <= driven_job.op;
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // Result monitor with random back-pressure
   always @(posedge clock) begin
      job_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, status %h data %h", $time, rsp_tuser,
                        rsp_tdata);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", want.status, rsp_tuser);
               check_field("out_data", want.data, rsp_tdata[31:0]);
               check_field("out_priority", want.prio, rsp_tdata[63:32]);
               check_field("occupancy", want.occupancy, rsp_tdata[68:64]);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Stimulus and end of test
   initial begin
      int          made;
      int          phase_len;
      int          insert_pct;
      int          k;
      logic [31:0] d;

      // directed: empty pop, extremes, tie handling, full queue
      add_job(OP_REMOVE, 32'h0, 32'h0);
      add_job(OP_INSERT, 32'h7fff_ffff, 32'h8000_0000);
      add_job(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);
      add_job(OP_INSERT, 32'hffff_ffff, 32'h0);
      add_job(OP_INSERT, 32'h0000_0001, 32'hffff_ffff);
      add_job(OP_INSERT, 32'h0000_0002, 32'h0);           // tie behind stored job
      add_job(OP_INSERT, 32'h0000_0003, 32'h8000_0000);   // tie with head goes first
      add_job(OP_REMOVE, 32'hffff_ffff, 32'hffff_ffff);   // fields ignored
      for (k = 0; k < 11; k++)
         add_job(OP_INSERT, 32'h100 + k, 32'd3 + (k % 3));
      add_job(OP_INSERT, 32'hdead_beef, 32'h8000_0000);   // rejected, queue full
      for (k = 0; k < 3; k++)
         add_job(OP_REMOVE, 32'h0, 32'h0);

      // random phases biased toward filling, draining or neither
      made = 0;
      while (made < RANDOM_JOBS) begin
         case ($urandom_range(0, 2))
            0:       insert_pct = 80;
            1:       insert_pct = 20;
            default: insert_pct = 50;
         endcase
         phase_len = $urandom_range(10, 50);
         for (k = 0; k < phase_len; k++) begin
            d = $urandom;
            if ($urandom_range(0, 99) < insert_pct)
               add_job(OP_INSERT, d, pick_prio());
            else
               add_job(OP_REMOVE, d, $urandom);
            made++;
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_jobs.size() != 0 || req_tvalid)
         @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (expected_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_results.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
